[src/u8cp_pkg.sv]
// Shared types, constants and character map functions for the UTF-8 / Windows-1252 transcoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8cp_pkg;

	localparam logic [7:0] BYTE_QMARK = 8'h3F;

	// Decode side result.
	typedef struct packed {
		logic [7:0] single_byte_out;
		logic [2:0] consumed_len;
	} dec_res_t;

	// Encode side result.
	typedef struct packed {
		logic [7:0] enc_byte0;
		logic [7:0] enc_byte1;
		logic [7:0] enc_byte2;
		logic [1:0] enc_len;
		logic       status;
	} enc_res_t;

	// Map a code point to a Windows-1252 byte; '?' where there is none.
	function automatic logic [7:0] code_to_cp1252(input logic [20:0] code);
		logic [7:0] res;
		res = BYTE_QMARK;
		if (code <= 21'h00007F || (code >= 21'h0000A0 && code <= 21'h0000FF)) begin
			res = code[7:0];
		end else begin
			unique case (code)
				21'h0020AC: res = 8'h80;
				21'h00201A: res = 8'h82;
				21'h000192: res = 8'h83;
				21'h00201E: res = 8'h84;
				21'h002026: res = 8'h85;
				21'h002020: res = 8'h86;
				21'h002021: res = 8'h87;
				21'h0002C6: res = 8'h88;
				21'h002030: res = 8'h89;
				21'h000160: res = 8'h8A;
				21'h002039: res = 8'h8B;
				21'h000152: res = 8'h8C;
				21'h00017D: res = 8'h8E;
				21'h002018: res = 8'h91;
				21'h002019: res = 8'h92;
				21'h00201C: res = 8'h93;
				21'h00201D: res = 8'h94;
				21'h002022: res = 8'h95;
				21'h002013: res = 8'h96;
				21'h002014: res = 8'h97;
				21'h0002DC: res = 8'h98;
				21'h002122: res = 8'h99;
				21'h000161: res = 8'h9A;
				21'h00203A: res = 8'h9B;
				21'h000153: res = 8'h9C;
				21'h00017E: res = 8'h9E;
				21'h000178: res = 8'h9F;
				default:    res = BYTE_QMARK;
			endcase
		end
		return res;
	endfunction

	// Map a Windows-1252 byte to its code point; undefined bytes map to themselves.
	function automatic logic [15:0] cp1252_to_code(input logic [7:0] b);
		logic [15:0] res;
		unique case (b)
			8'h80:   res = 16'h20AC;
			8'h82:   res = 16'h201A;
			8'h83:   res = 16'h0192;
			8'h84:   res = 16'h201E;
			8'h85:   res = 16'h2026;
			8'h86:   res = 16'h2020;
			8'h87:   res = 16'h2021;
			8'h88:   res = 16'h02C6;
			8'h89:   res = 16'h2030;
			8'h8A:   res = 16'h0160;
			8'h8B:   res = 16'h2039;
			8'h8C:   res = 16'h0152;
			8'h8E:   res = 16'h017D;
			8'h91:   res = 16'h2018;
			8'h92:   res = 16'h2019;
			8'h93:   res = 16'h201C;
			8'h94:   res = 16'h201D;
			8'h95:   res = 16'h2022;
			8'h96:   res = 16'h2013;
			8'h97:   res = 16'h2014;
			8'h98:   res = 16'h02DC;
			8'h99:   res = 16'h2122;
			8'h9A:   res = 16'h0161;
			8'h9B:   res = 16'h203A;
			8'h9C:   res = 16'h0153;
			8'h9E:   res = 16'h017E;
			8'h9F:   res = 16'h0178;
			default: res = {8'h00, b};
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

[src/u8cp_decode.sv]
// UTF-8 sequence decode and code point to Windows-1252 map, combinational.
// Depends on u8cp_pkg.
`default_nettype none

module u8cp_decode import u8cp_pkg::*; (
	input  wire logic [7:0] in_byte0,
	input  wire logic [7:0] in_byte1,
	input  wire logic [7:0] in_byte2,
	input  wire logic [7:0] in_byte3,
	input  wire logic [2:0] in_avail,
	output dec_res_t        res
);

	logic [2:0]  avail;
	logic        c1, c2, c3;
	logic        ok;
	logic [2:0]  used;
	logic [20:0] code;

	// Saturate: anything above four means four.
	assign avail = in_avail[2] ? 3'd4 : in_avail;
	assign c1 = (in_byte1[7:6] == 2'b10);
	assign c2 = (in_byte2[7:6] == 2'b10);
	assign c3 = (in_byte3[7:6] == 2'b10);

	always_comb begin
		ok   = 1'b0;
		used = 3'd1;
		code = '0;
		priority if (avail == 3'd0) begin
			used = 3'd0;
		end else if (!in_byte0[7]) begin
			ok   = 1'b1;
			code = {13'b0, in_byte0};
		end else if (in_byte0[7:5] == 3'b110 && avail >= 3'd2 && c1) begin
			ok   = 1'b1;
			used = 3'd2;
			code = {10'b0, in_byte0[4:0], in_byte1[5:0]};
		end else if (in_byte0[7:4] == 4'b1110 && avail >= 3'd3 && c1 && c2) begin
			ok   = 1'b1;
			used = 3'd3;
			code = {5'b0, in_byte0[3:0], in_byte1[5:0], in_byte2[5:0]};
		end else if (in_byte0[7:3] == 5'b11110 && avail == 3'd4 && c1 && c2 && c3) begin
			ok   = 1'b1;
			used = 3'd4;
			code = {in_byte0[2:0], in_byte1[5:0], in_byte2[5:0], in_byte3[5:0]};
		end else begin
			used = 3'd1;
		end
	end

	assign res.single_byte_out = ok ? code_to_cp1252(code) : BYTE_QMARK;
	assign res.consumed_len    = used;

endmodule

`default_nettype wire

[src/u8cp_encode.sv]
// Windows-1252 byte to code point map and UTF-8 encode with room check, combinational.
// Depends on u8cp_pkg.
`default_nettype none

module u8cp_encode import u8cp_pkg::*; (
	input  wire logic [7:0] single_byte_in,
	input  wire logic [1:0] out_room,
	output enc_res_t        res
);

	logic [15:0] code;
	logic [1:0]  len;
	logic [7:0]  e0, e1, e2;
	logic        short_room;

	assign code = cp1252_to_code(single_byte_in);

	always_comb begin
		priority if (code <= 16'h007F) begin
			len = 2'd1;
			e0  = code[7:0];
			e1  = 8'h00;
			e2  = 8'h00;
		end else if (code <= 16'h07FF) begin
			len = 2'd2;
			e0  = {3'b110, code[10:6]};
			e1  = {2'b10, code[5:0]};
			e2  = 8'h00;
		end else begin
			len = 2'd3;
			e0  = {4'b1110, code[15:12]};
			e1  = {2'b10, code[11:6]};
			e2  = {2'b10, code[5:0]};
		end
	end

	// Drop the bytes when the destination cannot hold them.
	assign short_room    = (out_room < len);
	assign res.enc_len   = len;
	assign res.status    = short_room;
	assign res.enc_byte0 = short_room ? 8'h00 : e0;
	assign res.enc_byte1 = short_room ? 8'h00 : e1;
	assign res.enc_byte2 = short_room ? 8'h00 : e2;

endmodule

`default_nettype wire

[src/utf8_cp1252_transcoder_core.sv]
// UTF-8 / Windows-1252 single character transcoder, streaming top level.
// An accepted word is registered in data_s1; its decode/encode result in result_s2.
// Throughput: one word per cycle while m_tready allows; each register holds one word.
// Reset (arst_n low) clears both stage valid flags; payload registers are not reset.
// Depends on u8cp_pkg, u8cp_decode and u8cp_encode.
`default_nettype none

module utf8_cp1252_transcoder_core import u8cp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// in_byte0[7:0], in_byte1[15:8], in_byte2[23:16], in_byte3[31:24],
	// in_avail[34:32], single_byte_in[42:35], out_room[44:43], zero pad [47:45]
	input  wire logic [47:0] s_tdata,
	// opcode[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// single_byte_out[7:0], consumed_len[10:8], enc_byte0[18:11], enc_byte1[26:19],
	// enc_byte2[34:27], enc_len[36:35], status[37], zero pad [39:38]
	output logic [39:0]      m_tdata
);

	logic        valid_s1;
	logic        opcode_s1;
	logic [44:0] data_s1;
	logic        valid_s2;
	logic [37:0] result_s2;
	logic        adv_s1, adv_s2;
	dec_res_t    dec_res;
	enc_res_t    enc_res;
	dec_res_t    dec_sel;
	enc_res_t    enc_sel;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			opcode_s1 <= s_tuser;
			data_s1   <= s_tdata[44:0];
		end
	end

	u8cp_decode u_dec (
		.in_byte0 (data_s1[7:0]),
		.in_byte1 (data_s1[15:8]),
		.in_byte2 (data_s1[23:16]),
		.in_byte3 (data_s1[31:24]),
		.in_avail (data_s1[34:32]),
		.res      (dec_res)
	);

	u8cp_encode u_enc (
		.single_byte_in (data_s1[42:35]),
		.out_room       (data_s1[44:43]),
		.res            (enc_res)
	);

	// Zero the half that the opcode does not use.
	assign dec_sel = opcode_s1 ? '0 : dec_res;
	assign enc_sel = opcode_s1 ? enc_res : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= {enc_sel.status, enc_sel.enc_len, enc_sel.enc_byte2,
				enc_sel.enc_byte1, enc_sel.enc_byte0, dec_sel.consumed_len,
				dec_sel.single_byte_out};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, result_s2};

endmodule

`default_nettype wire
